// ===== hdl/wdog_pkg.sv =====
// ----------------------------------------------------------------------------
// wdog_pkg
// Types, register offsets, bit positions and key values for the watchdog.
// ----------------------------------------------------------------------------
package wdog_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned OFS_W   = 3;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned COUNT_W = 9;

  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [OFS_W-1:0] OFS_CTL = 3'd0;
  localparam logic [OFS_W-1:0] OFS_SVC = 3'd2;
  localparam logic [OFS_W-1:0] OFS_ICR = 3'd6;

  localparam logic [DATA_W-1:0] KEY_ONE = 16'h5555;
  localparam logic [DATA_W-1:0] KEY_TWO = 16'hAAAA;

  localparam logic [DATA_W-1:0] CTL_RESET_VALUE = 16'h0010;

  // control register bits
  localparam int unsigned CTL_SOFT_RESET = 4;
  localparam int unsigned CTL_RESET_EN   = 3;
  localparam int unsigned CTL_ENABLE     = 2;

  // interrupt control register bits
  localparam int unsigned ICR_IRQ_EN = 15;
  localparam int unsigned ICR_STATUS = 14;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [OFS_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_data;
  } wdog_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               timeout_reset;
    logic               software_reset;
    logic               irq_pending;
    logic [COUNT_W-1:0] remaining;
  } wdog_rsp_t;

endpackage

// ===== hdl/wdog_core.sv =====
// ----------------------------------------------------------------------------
// wdog_core
// Watchdog register file and counter; one request updated per strobe.
// ----------------------------------------------------------------------------
module wdog_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wdog_pkg::wdog_req_t req,
  output wdog_pkg::wdog_rsp_t rsp
);
  import wdog_pkg::*;

  logic [DATA_W-1:0]  control_reg, control_reg_next;
  logic [DATA_W-1:0]  irq_control_reg, irq_control_reg_next;
  logic [COUNT_W-1:0] countdown, countdown_next;
  logic               first_key_seen, first_key_seen_next;

  logic [COUNT_W-1:0] cd_dec;
  logic [COUNT_W-1:0] full_cur;
  logic [COUNT_W-1:0] full_new;
  logic [DATA_W-1:0]  ctl_wr;
  logic               status_keep;

  assign full_cur = {1'b0, control_reg[15:8]} + COUNT_W'(1);
  assign cd_dec   = (countdown != '0) ? countdown - COUNT_W'(1) : countdown;
  assign ctl_wr   = req.write_data | CTL_RESET_VALUE
                  | (control_reg & (DATA_W'(1) << CTL_ENABLE));
  assign full_new = {1'b0, ctl_wr[15:8]} + COUNT_W'(1);
  assign status_keep = irq_control_reg[ICR_STATUS] & ~req.write_data[ICR_STATUS];

  always_comb begin
    control_reg_next     = control_reg;
    irq_control_reg_next = irq_control_reg;
    countdown_next       = countdown;
    first_key_seen_next  = first_key_seen;
    rsp                  = '0;

    unique case (req.action)
      ACT_TICK: begin
        if (control_reg[CTL_ENABLE]) begin
          countdown_next = cd_dec;
          if (cd_dec == {1'b0, irq_control_reg[7:0]}) begin
            irq_control_reg_next[ICR_STATUS] = 1'b1;
          end
          if (cd_dec == '0) begin
            rsp.timeout_reset = control_reg[CTL_RESET_EN];
            countdown_next    = full_cur;
          end
        end
      end
      ACT_WRITE: begin
        priority if (req.reg_offset == OFS_CTL) begin
          rsp.software_reset = ~req.write_data[CTL_SOFT_RESET];
          control_reg_next   = ctl_wr;
          if (!control_reg[CTL_ENABLE] && ctl_wr[CTL_ENABLE]) begin
            countdown_next = full_new;
          end
        end else if (req.reg_offset == OFS_SVC) begin
          if (req.write_data == KEY_ONE) begin
            first_key_seen_next = 1'b1;
          end else if (req.write_data == KEY_TWO && first_key_seen) begin
            countdown_next      = full_cur;
            first_key_seen_next = 1'b0;
          end else begin
            first_key_seen_next = 1'b0;
          end
        end else if (req.reg_offset == OFS_ICR) begin
          irq_control_reg_next = '0;
          irq_control_reg_next[ICR_IRQ_EN] = irq_control_reg[ICR_IRQ_EN]
                                           | req.write_data[ICR_IRQ_EN];
          irq_control_reg_next[ICR_STATUS] = status_keep;
          irq_control_reg_next[7:0]        = req.write_data[7:0];
        end else begin
        end
      end
      ACT_READ: begin
        if (req.reg_offset == OFS_CTL) begin
          rsp.read_data = control_reg;
        end else if (req.reg_offset == OFS_ICR) begin
          rsp.read_data = irq_control_reg;
        end
      end
      default: begin
      end
    endcase

    rsp.irq_pending = irq_control_reg_next[ICR_STATUS] & irq_control_reg_next[ICR_IRQ_EN];
    rsp.remaining   = countdown_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg     <= CTL_RESET_VALUE;
      irq_control_reg <= '0;
      countdown       <= COUNT_W'(1);
      first_key_seen  <= 1'b0;
    end else if (step) begin
      control_reg     <= control_reg_next;
      irq_control_reg <= irq_control_reg_next;
      countdown       <= countdown_next;
      first_key_seen  <= first_key_seen_next;
    end
  end

endmodule

// ===== hdl/watchdog_with_service_sequence.sv =====
// ----------------------------------------------------------------------------
// watchdog_with_service_sequence
// 16-bit watchdog with a two-key service sequence and pre-timeout interrupt.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one request per item:
//   a half-second tick, a register write or a register read. Output channel
//   (out_valid/out_ready/out_data) returns exactly one result per request:
//   read data, timeout and software reset pulses, interrupt pending and the
//   half-seconds remaining.
//   The request is captured in an input register; the watchdog state is
//   updated as it moves into the output register.
//   Throughput is one request per cycle while the receiver does not stall;
//   the single state update per cycle sets that figure.
//   When the receiver stalls, the output register holds its result and the
//   input register still takes one more request; in_ready then drops until
//   the result is taken.
//   Reset (rst, synchronous) empties both registers and returns the state to
//   control 0x0010, interrupt control 0, counter 1, service sequence unarmed.
// ----------------------------------------------------------------------------
module watchdog_with_service_sequence (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wdog_pkg::wdog_req_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wdog_pkg::wdog_rsp_t out_data
);
  import wdog_pkg::*;

  logic      req_valid;
  wdog_req_t req;
  wdog_rsp_t rsp;
  logic      step;

  // request moves into the result register when it is empty or being drained
  assign step     = req_valid & (~out_valid | out_ready);
  assign in_ready = ~req_valid | step;

  wdog_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .req  (req),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (~out_valid | out_ready) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= rsp;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the watchdog: ticks, register writes and reads.
// A shadow copy of the watchdog state predicts every response. Responses are
// checked in order, field by field. Traffic is a directed opener, then mostly
// well-formed service, control and interrupt-control sequences mixed with
// noise. Requests arrive with random gaps; responses see random back-pressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wdog_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned HOLD_AT     = 600;
  localparam int unsigned HOLD_CYCLES = 100;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned RANDOM_REQS = 1550;
  localparam int unsigned CNT_LSB_W   = 8;

  typedef struct packed {
    wdog_req_t  req;
    logic [3:0] gap_cap;
    logic       drain;
  } pending_req_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  wdog_req_t in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  wdog_rsp_t out_data;

  pending_req_t pending_reqs[$];
  wdog_rsp_t    expected_rsps[$];

  // shadow watchdog state
  logic [DATA_W-1:0]  ctl_shadow;
  logic [DATA_W-1:0]  icr_shadow;
  logic [COUNT_W-1:0] count_shadow;
  logic               key_armed;

  logic        req_taken = 1'b0;
  logic        rsp_taken = 1'b0;
  int unsigned reqs_accepted = 0;
  int unsigned rsps_taken = 0;
  int unsigned total_reqs;
  int unsigned fail_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          hold_done = 1'b0;

  // stimulus build controls
  logic [3:0]  gap_cap_now = 4'd14;
  logic        drain_next = 1'b0;

  watchdog_with_service_sequence dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [COUNT_W-1:0] reload_count();
    return COUNT_W'(ctl_shadow[15:8]) + 1'b1;
  endfunction

  // apply one request to the shadow state and return the response it causes
  function automatic wdog_rsp_t advance_watchdog(wdog_req_t r);
    wdog_rsp_t rsp;
    logic      was_on;
    logic      status;
    logic      irq_en;
    rsp = '0;
    case (r.action)
      ACT_TICK: begin
        if (ctl_shadow[CTL_ENABLE]) begin
          if (count_shadow != '0) count_shadow = count_shadow - 1'b1;
          if (count_shadow == COUNT_W'(icr_shadow[CNT_LSB_W-1:0]))
            icr_shadow[ICR_STATUS] = 1'b1;
          if (count_shadow == '0) begin
            rsp.timeout_reset = ctl_shadow[CTL_RESET_EN];
            count_shadow = reload_count();
          end
        end
      end
      ACT_WRITE: begin
        case (r.reg_offset)
          OFS_CTL: begin
            was_on = ctl_shadow[CTL_ENABLE];
            rsp.software_reset = !r.write_data[CTL_SOFT_RESET];
            ctl_shadow = r.write_data;
            ctl_shadow[CTL_SOFT_RESET] = 1'b1;
            ctl_shadow[CTL_ENABLE] = ctl_shadow[CTL_ENABLE] | was_on;
            if (!was_on && ctl_shadow[CTL_ENABLE]) count_shadow = reload_count();
          end
          OFS_SVC: begin
            if (r.write_data == KEY_ONE) begin
              key_armed = 1'b1;
            end else if (r.write_data == KEY_TWO && key_armed) begin
              count_shadow = reload_count();
              key_armed = 1'b0;
            end else begin
              key_armed = 1'b0;
            end
          end
          OFS_ICR: begin
            // status is write-one-to-clear, interrupt enable is sticky
            status = icr_shadow[ICR_STATUS] && !r.write_data[ICR_STATUS];
            irq_en = icr_shadow[ICR_IRQ_EN] | r.write_data[ICR_IRQ_EN];
            icr_shadow = '0;
            icr_shadow[ICR_IRQ_EN] = irq_en;
            icr_shadow[ICR_STATUS] = status;
            icr_shadow[CNT_LSB_W-1:0] = r.write_data[CNT_LSB_W-1:0];
          end
          default: ;
        endcase
      end
      ACT_READ: begin
        if (r.reg_offset == OFS_CTL) rsp.read_data = ctl_shadow;
        else if (r.reg_offset == OFS_ICR) rsp.read_data = icr_shadow;
      end
      default: ;
    endcase
    rsp.irq_pending = icr_shadow[ICR_STATUS] & icr_shadow[ICR_IRQ_EN];
    rsp.remaining = count_shadow;
    return rsp;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic push_request(logic [ACT_W-1:0] act, logic [OFS_W-1:0] ofs,
                              logic [DATA_W-1:0] data);
    pending_req_t p;
    p.req.action = act;
    p.req.reg_offset = ofs;
    p.req.write_data = data;
    p.gap_cap = gap_cap_now;
    p.drain = drain_next;
    drain_next = 1'b0;
    pending_reqs.push_back(p);
  endtask

  // request driver
  always @(negedge clk) begin : driver
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !req_taken) begin
      // hold the request until it is accepted
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() > 0 &&
                 !(pending_reqs[0].drain && expected_rsps.size() > 0)) begin
      in_valid <= 1'b1;
      in_data <= pending_reqs[0].req;
      send_gap <= $urandom_range(pending_reqs[0].gap_cap, 0);
      void'(pending_reqs.pop_front());
    end else begin
      in_valid <= 1'b0;
    end
  end

  // response back-pressure
  always @(negedge clk) begin : receiver
    int unsigned n;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (rsp_taken) begin
      if (!hold_done && rsps_taken >= HOLD_AT) begin
        n = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if ((rsps_taken / 150) % 3 == 1) begin
        n = 0;
      end else begin
        n = $urandom_range(14, 0);
      end
      stall_left <= n;
      out_ready <= (n == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // request capture and response check share one process so that order is fixed
  always @(posedge clk) begin : monitor
    wdog_rsp_t want;
    req_taken <= !rst && in_valid && in_ready;
    rsp_taken <= !rst && out_valid && out_ready;
    if (!rst && in_valid && in_ready) begin
      expected_rsps.push_back(advance_watchdog(in_data));
      reqs_accepted <= reqs_accepted + 1;
    end
    if (!rst && out_valid && out_ready) begin
      rsps_taken <= rsps_taken + 1;
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response, read_data", out_data.read_data, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.timeout_reset !== want.timeout_reset)
          report_mismatch("timeout_reset", out_data.timeout_reset, want.timeout_reset);
        if (out_data.software_reset !== want.software_reset)
          report_mismatch("software_reset", out_data.software_reset, want.software_reset);
        if (out_data.irq_pending !== want.irq_pending)
          report_mismatch("irq_pending", out_data.irq_pending, want.irq_pending);
        if (out_data.remaining !== want.remaining)
          report_mismatch("remaining", out_data.remaining, want.remaining);
      end
    end
  end

  always @(posedge clk) begin : hang_check
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]  tmo;
    logic [15:0] wd;
    int unsigned pick;
    int unsigned next_mark;
    int unsigned next_drain;

    ctl_shadow = CTL_RESET_VALUE;
    icr_shadow = '0;
    count_shadow = COUNT_W'(1);
    key_armed = 1'b0;

    // reset state, unknown offsets and actions, tick while disabled
    gap_cap_now = 4'd0;
    push_request(ACT_READ, OFS_CTL, 16'h0000);
    push_request(ACT_READ, OFS_ICR, 16'hFFFF);
    push_request(ACT_READ, OFS_SVC, 16'h0000);
    push_request(ACT_READ, 3'd7, 16'h0000);
    push_request(2'd3, 3'd7, 16'hFFFF);
    push_request(ACT_TICK, OFS_CTL, 16'h0000);
    push_request(ACT_WRITE, 3'd4, 16'hFFFF);
    push_request(ACT_WRITE, OFS_CTL, 16'h0000);
    push_request(ACT_READ, OFS_CTL, 16'h0000);
    // enable with timeout 4, pre-timeout at 2, interrupt still off
    push_request(ACT_WRITE, OFS_ICR, 16'h4002);
    push_request(ACT_WRITE, OFS_CTL, 16'h030C);
    push_request(ACT_TICK, OFS_CTL, 16'h0000);
    push_request(ACT_TICK, OFS_CTL, 16'h0000);
    // repeated first key, second key with and without arming
    push_request(ACT_WRITE, OFS_SVC, KEY_ONE);
    push_request(ACT_WRITE, OFS_SVC, KEY_ONE);
    push_request(ACT_WRITE, OFS_SVC, KEY_TWO);
    push_request(ACT_WRITE, OFS_SVC, KEY_TWO);
    // other register write between the keys keeps the sequence armed
    push_request(ACT_WRITE, OFS_SVC, KEY_ONE);
    push_request(ACT_WRITE, OFS_ICR, 16'hC002);
    push_request(ACT_WRITE, OFS_SVC, KEY_TWO);
    // run to expiry with reset enabled
    repeat (4) push_request(ACT_TICK, OFS_CTL, 16'h0000);
    push_request(ACT_READ, OFS_ICR, 16'h0000);
    // enable is sticky; largest timeout, then smallest
    push_request(ACT_WRITE, OFS_CTL, 16'hFF10);
    push_request(ACT_TICK, OFS_CTL, 16'h0000);
    push_request(ACT_WRITE, OFS_CTL, 16'h00FF);
    push_request(ACT_TICK, OFS_CTL, 16'h0000);

    next_mark = 0;
    next_drain = 500;
    while (pending_reqs.size() < RANDOM_REQS + 26) begin
      if (pending_reqs.size() >= next_mark) begin
        gap_cap_now = ($urandom_range(2, 0) == 0) ? 4'd0 : 4'd14;
        next_mark = next_mark + 100;
      end
      if (pending_reqs.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain = next_drain + 500;
      end
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
        repeat ($urandom_range(20, 1)) push_request(ACT_TICK, 3'($urandom), 16'($urandom));
      end else if (pick < 45) begin
        push_request(ACT_WRITE, OFS_SVC, KEY_ONE);
        if ($urandom_range(3, 0) == 0) begin
          if ($urandom_range(1, 0) == 0) push_request(ACT_READ, OFS_CTL, 16'($urandom));
          else push_request(ACT_WRITE, OFS_ICR, 16'($urandom) & 16'h80FF);
        end
        if ($urandom_range(4, 0) == 0) push_request(ACT_WRITE, OFS_SVC, 16'($urandom));
        else push_request(ACT_WRITE, OFS_SVC, KEY_TWO);
      end else if (pick < 55) begin
        tmo = ($urandom_range(9, 0) == 0) ? 8'($urandom) : 8'($urandom_range(12, 0));
        wd = {tmo, 8'($urandom)};
        push_request(ACT_WRITE, OFS_CTL, wd);
      end else if (pick < 65) begin
        wd = 16'($urandom);
        if ($urandom_range(3, 0) != 0) wd[7:0] = 8'($urandom_range(12, 0));
        push_request(ACT_WRITE, OFS_ICR, wd);
      end else if (pick < 82) begin
        case ($urandom_range(2, 0))
          0: push_request(ACT_READ, OFS_CTL, 16'($urandom));
          1: push_request(ACT_READ, OFS_ICR, 16'($urandom));
          default: push_request(ACT_READ, 3'($urandom), 16'($urandom));
        endcase
      end else begin
        push_request(2'($urandom), 3'($urandom), 16'($urandom));
      end
    end
    total_reqs = pending_reqs.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (reqs_accepted != total_reqs || expected_rsps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
